### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Implication with a fixed number of cycles between the two sides.
`define AST_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("delayed check failed");

`endif

### rtl/core/htc_pkg.sv
// Types and constants of the humidity/temperature calibration block.
`timescale 1ns / 1ps

package htc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int TEMP_SHIFT  = 5;
	localparam int HUM_SHIFT   = 7;
	localparam int QUO_W       = 31;
	localparam int DEN_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 16;

	typedef logic signed [15:0] raw_t;
	typedef logic signed [16:0] diff_t;
	typedef logic signed [10:0] dp_t;
	typedef logic signed [27:0] prod_t;
	typedef logic signed [34:0] scaled_t;
	typedef logic [QUO_W-1:0]   quo_t;
	typedef logic [DEN_W-1:0]   den_t;
	typedef logic [DEN_W:0]     trial_t;
	typedef logic [14:0]        base_t;
	typedef logic signed [31:0] value_t;
	typedef logic signed [32:0] sum_t;
	typedef logic [9:0]         tpoint_t;
	typedef logic [7:0]         hpoint_t;

	localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam value_t VALUE_MIN = 32'sh8000_0000;

	typedef enum logic [0:0] {
		OP_TEMP = 1'b0,
		OP_HUM  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_P0 = 3'd0,
		REG_TEMP_P1 = 3'd1,
		REG_TEMP_R0 = 3'd2,
		REG_TEMP_R1 = 3'd3,
		REG_HUM_P0  = 3'd4,
		REG_HUM_P1  = 3'd5,
		REG_HUM_R0  = 3'd6,
		REG_HUM_R1  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		op_t  opcode;
		raw_t raw_sample;
	} in_t;

	typedef struct packed {
		value_t calibrated_value;
		logic   zero_divide;
		logic   saturated;
	} out_t;

	// classified item passed from front to back
	typedef struct packed {
		diff_t diff;
		dp_t   dp;
		diff_t den;
		base_t base;
		logic  hum;
		logic  zdiv;
	} entry_t;

	typedef struct packed {
		prod_t prod;
		diff_t den;
		base_t base;
		logic  hum;
		logic  zdiv;
	} mul_t;

	typedef struct packed {
		den_t  rem;
		quo_t  numq;
		den_t  den;
		logic  q_neg;
		base_t base;
		logic  zdiv;
	} div_t;

endpackage

### rtl/core/humidity_temperature_calibration_top.sv
// Pipeline: 36 register stages from the edge that takes start (front 1, queue 1, multiply 1,
// sign split 1, divider 31 one bit per stage, output 1); done and result leave the output register.
// Throughput: one item per cycle; the divider is fully pipelined, so busy stays low.
// Reset (arst_n low) clears all calibration registers to zero and empties every stage.
// Results cannot be held off by the receiver; done strobes for one cycle per item.
`timescale 1ns / 1ps

module humidity_temperature_calibration_top #(
	parameter int QUEUE_DEPTH = htc_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  htc_pkg::in_t                  cmd,
	input  logic                          cfg_we,
	input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [htc_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          done,
	output htc_pkg::out_t                 result
);

	logic            push, full, pop;
	htc_pkg::entry_t f_entry, q_entry;

	htc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.full      (full),
		.push      (push),
		.entry     (f_entry)
	);

	htc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_entry),
		.full   (full),
		.pop    (pop),
		.dout   (q_entry)
	);

	htc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop),
		.in_entry (q_entry),
		.done     (done),
		.result   (result)
	);

endmodule

### rtl/core/htc_front.sv
// Front end: configuration registers, command intake and classification.
`timescale 1ns / 1ps

module htc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  htc_pkg::in_t                        cmd,
	input  logic                                cfg_we,
	input  logic [htc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [htc_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                full,
	output logic                                push,
	output htc_pkg::entry_t                     entry
);

	htc_pkg::tpoint_t tp0_q, tp1_q;
	htc_pkg::hpoint_t hp0_q, hp1_q;
	htc_pkg::raw_t    tr0_q, tr1_q, hr0_q, hr1_q;

	logic             valid_s1;
	htc_pkg::entry_t  entry_s1;
	htc_pkg::entry_t  entry_d;
	logic             advance;
	logic             hum;
	logic [9:0]       p0, p1;
	htc_pkg::raw_t    r0, r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp0_q <= '0;
			tp1_q <= '0;
			tr0_q <= '0;
			tr1_q <= '0;
			hp0_q <= '0;
			hp1_q <= '0;
			hr0_q <= '0;
			hr1_q <= '0;
		end else if (cfg_we) begin
			case (htc_pkg::cfg_reg_t'(cfg_idx))
				htc_pkg::REG_TEMP_P0: tp0_q <= cfg_wdata[9:0];
				htc_pkg::REG_TEMP_P1: tp1_q <= cfg_wdata[9:0];
				htc_pkg::REG_TEMP_R0: tr0_q <= cfg_wdata;
				htc_pkg::REG_TEMP_R1: tr1_q <= cfg_wdata;
				htc_pkg::REG_HUM_P0:  hp0_q <= cfg_wdata[7:0];
				htc_pkg::REG_HUM_P1:  hp1_q <= cfg_wdata[7:0];
				htc_pkg::REG_HUM_R0:  hr0_q <= cfg_wdata;
				htc_pkg::REG_HUM_R1:  hr1_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		hum = (cmd.opcode == htc_pkg::OP_HUM);
		p0  = hum ? {2'b00, hp0_q} : tp0_q;
		p1  = hum ? {2'b00, hp1_q} : tp1_q;
		r0  = hum ? hr0_q : tr0_q;
		r1  = hum ? hr1_q : tr1_q;
		entry_d.diff = {cmd.raw_sample[15], cmd.raw_sample} - {r0[15], r0};
		entry_d.den  = {r1[15], r1} - {r0[15], r0};
		entry_d.dp   = {1'b0, p1} - {1'b0, p0};
		entry_d.base = hum ? (htc_pkg::base_t'(hp0_q) << htc_pkg::HUM_SHIFT)
			: (htc_pkg::base_t'(tp0_q) << htc_pkg::TEMP_SHIFT);
		entry_d.hum  = hum;
		entry_d.zdiv = (r1 == r0);
	end

	assign advance = !valid_s1 || !full;
	assign busy    = !advance;
	assign push    = valid_s1 && !full;
	assign entry   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && start) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

### rtl/core/htc_queue.sv
// Short queue between front and back ends.
`timescale 1ns / 1ps

module htc_queue #(
	parameter int DEPTH = htc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  htc_pkg::entry_t din,
	output logic            full,
	output logic            pop,
	output htc_pkg::entry_t dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	htc_pkg::entry_t  mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign pop     = (count_q != '0);
	assign do_push = push && !full;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/htc_back.sv
// Back end: multiply, one-bit-per-stage divider pipeline, offset and saturation.
`timescale 1ns / 1ps

module htc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  htc_pkg::entry_t in_entry,
	output logic            done,
	output htc_pkg::out_t   result
);

	localparam int QW = htc_pkg::QUO_W;

	logic              vld_s1;
	htc_pkg::mul_t     mul_s1;
	logic              dvld_s [QW+1];
	htc_pkg::div_t     dpay_s [QW+1];
	logic              done_q;
	htc_pkg::out_t     result_q;

	htc_pkg::scaled_t  scaled, scaled_mag;
	htc_pkg::diff_t    den_mag;
	htc_pkg::div_t     prep;
	htc_pkg::div_t     last;
	htc_pkg::sum_t     qs, sum;
	htc_pkg::out_t     res_d;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1.prod <= in_entry.diff * in_entry.dp;
		mul_s1.den  <= in_entry.den;
		mul_s1.base <= in_entry.base;
		mul_s1.hum  <= in_entry.hum;
		mul_s1.zdiv <= in_entry.zdiv;
	end

	// scale and split into sign and magnitudes
	always_comb begin
		scaled = mul_s1.hum ? (htc_pkg::scaled_t'(mul_s1.prod) <<< htc_pkg::HUM_SHIFT)
			: (htc_pkg::scaled_t'(mul_s1.prod) <<< htc_pkg::TEMP_SHIFT);
		scaled_mag = scaled[34] ? -scaled : scaled;
		den_mag    = mul_s1.den[16] ? -mul_s1.den : mul_s1.den;
		prep.rem   = '0;
		prep.numq  = scaled_mag[QW-1:0];
		prep.den   = den_mag[htc_pkg::DEN_W-1:0];
		prep.q_neg = scaled[34] ^ mul_s1.den[16];
		prep.base  = mul_s1.base;
		prep.zdiv  = mul_s1.zdiv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s[0] <= 1'b0;
		end else begin
			dvld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dpay_s[0] <= prep;
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		htc_pkg::trial_t trial;
		logic            ge;

		always_comb begin
			trial = {dpay_s[k].rem, dpay_s[k].numq[QW-1]};
			ge    = (trial >= {1'b0, dpay_s[k].den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k+1] <= 1'b0;
			end else begin
				dvld_s[k+1] <= dvld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dpay_s[k+1].rem   <= ge ? htc_pkg::den_t'(trial - {1'b0, dpay_s[k].den})
				: trial[htc_pkg::DEN_W-1:0];
			dpay_s[k+1].numq  <= {dpay_s[k].numq[QW-2:0], ge};
			dpay_s[k+1].den   <= dpay_s[k].den;
			dpay_s[k+1].q_neg <= dpay_s[k].q_neg;
			dpay_s[k+1].base  <= dpay_s[k].base;
			dpay_s[k+1].zdiv  <= dpay_s[k].zdiv;
		end
	end

	// offset, saturation
	always_comb begin
		last = dpay_s[QW];
		qs   = htc_pkg::sum_t'(last.numq);
		sum  = htc_pkg::sum_t'(last.base);
		if (!last.zdiv) begin
			sum = sum + (last.q_neg ? -qs : qs);
		end
		res_d.zero_divide = last.zdiv;
		res_d.saturated   = (sum[32] != sum[31]);
		if (sum[32] != sum[31]) begin
			res_d.calibrated_value = sum[32] ? htc_pkg::VALUE_MIN : htc_pkg::VALUE_MAX;
		end else begin
			res_d.calibrated_value = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dvld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### rtl/core/htc_checker.sv
// Port-level checker for the calibration block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input htc_pkg::out_t result
);

	`AST_DELAY(a_fixed_latency, clk, arst_n, start && !busy, 36, done)
	`AST_IMPLY(a_never_busy, clk, arst_n, 1'b1, !busy)
	`AST_IMPLY(a_flags_exclusive, clk, arst_n, done, !(result.zero_divide && result.saturated))
	`AST_IMPLY(a_sat_clamped, clk, arst_n, done && result.saturated, result.calibrated_value == htc_pkg::VALUE_MAX || result.calibrated_value == htc_pkg::VALUE_MIN)
	`AST_IMPLY(a_zdiv_base, clk, arst_n, done && result.zero_divide, result.calibrated_value[4:0] == 5'd0)

endmodule

bind humidity_temperature_calibration_top htc_checker u_htc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### sim/testbench.sv
// Self-checking testbench for the two-point humidity/temperature calibration block.
`timescale 1ns / 1ps

module testbench;
	import htc_pkg::*;

	localparam int DRAIN_SETTLE   = 3;
	localparam int END_SETTLE     = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_SETS    = 10;
	localparam int SET_SAMPLES    = 145;
	localparam int MAX_PRINTED    = 40;

	typedef enum {STEP_SAMPLE, STEP_WRITE, STEP_DRAIN} step_kind_e;

	typedef struct {
		step_kind_e  kind;
		in_t         cmd;
		cfg_reg_t    idx;
		logic [15:0] data;
	} step_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	in_t            cmd = '0;
	logic           cfg_we = 1'b0;
	logic [2:0]     cfg_idx = '0;
	logic [15:0]    cfg_wdata = '0;
	logic           busy;
	logic           done;
	out_t           result;

	step_t          steps[$];
	out_t           expected_q[$];
	logic [15:0]    cal_regs[8] = '{default: '0};
	logic [15:0]    plan_regs[8] = '{default: '0};

	step_t          cur_step;
	out_t           want;
	logic           nx_start;
	logic           nx_we;
	logic           feed_done = 1'b0;
	int             burst_left = 0;
	int             gap_left = 0;
	int             settle_cnt = 0;
	int             stall_cycles = 0;
	int             mismatches = 0;
	int             n_temp = 0;
	int             n_hum = 0;
	int             n_writes = 0;
	int             n_sets = 0;
	int             n_results = 0;
	int             n_zdiv = 0;

	humidity_temperature_calibration_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	always #1 clk = ~clk;

	function automatic out_t calibrate(in_t c);
		longint p0, p1, r0, r1, scale, acc;
		out_t o;
		if (c.opcode == OP_HUM) begin
			p0 = longint'(cal_regs[REG_HUM_P0]);
			p1 = longint'(cal_regs[REG_HUM_P1]);
			r0 = longint'($signed(cal_regs[REG_HUM_R0]));
			r1 = longint'($signed(cal_regs[REG_HUM_R1]));
			scale = 128;
		end else begin
			p0 = longint'(cal_regs[REG_TEMP_P0]);
			p1 = longint'(cal_regs[REG_TEMP_P1]);
			r0 = longint'($signed(cal_regs[REG_TEMP_R0]));
			r1 = longint'($signed(cal_regs[REG_TEMP_R1]));
			scale = 32;
		end
		o = '0;
		acc = p0 * scale;
		if (r1 == r0)
			o.zero_divide = 1'b1;
		else
			acc += (longint'($signed(c.raw_sample)) - r0) * (p1 - p0) * scale / (r1 - r0);
		if (acc > longint'(VALUE_MAX)) begin
			acc = longint'(VALUE_MAX);
			o.saturated = 1'b1;
		end else if (acc < longint'(VALUE_MIN)) begin
			acc = longint'(VALUE_MIN);
			o.saturated = 1'b1;
		end
		o.calibrated_value = acc[31:0];
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic add_sample(input op_t op, input logic [15:0] raw);
		step_t s;
		s = '{kind: STEP_SAMPLE, cmd: '0, idx: REG_TEMP_P0, data: '0};
		s.cmd.opcode = op;
		s.cmd.raw_sample = raw;
		steps.push_back(s);
	endtask

	task automatic add_drain();
		step_t s;
		s = '{kind: STEP_DRAIN, cmd: '0, idx: REG_TEMP_P0, data: '0};
		steps.push_back(s);
	endtask

	// drain the pipe, then write all eight calibration registers from plan_regs
	task automatic load_plan();
		step_t s;
		cfg_reg_t r;
		add_drain();
		r = r.first();
		for (int k = 0; k < 8; k++) begin
			s = '{kind: STEP_WRITE, cmd: '0, idx: r, data: plan_regs[r]};
			steps.push_back(s);
			r = r.next();
		end
		n_sets++;
	endtask

	task automatic add_random_sample();
		op_t op;
		cfg_reg_t r_base;
		logic [15:0] raw;
		op = op_t'($urandom_range(0, 1));
		r_base = (op == OP_HUM) ? REG_HUM_R0 : REG_TEMP_R0;
		case ($urandom_range(0, 9))
			0, 1: begin
				case ($urandom_range(0, 3))
					0: raw = 16'h8000;
					1: raw = 16'h7FFF;
					2: raw = 16'h0000;
					default: raw = 16'hFFFF;
				endcase
			end
			2, 3, 4: raw = plan_regs[int'(r_base) + $urandom_range(0, 1)]
				+ 16'($urandom_range(0, 128)) - 16'd64;
			default: raw = 16'($urandom);
		endcase
		add_sample(op, raw);
	endtask

	// driver: issues transfers in bursts, applies register writes between phases
	always @(posedge clk) begin
		if (arst_n) begin
			nx_start = 1'b0;
			nx_we = 1'b0;
			if (start && !busy) begin
				expected_q.push_back(calibrate(cmd));
				if (cmd.opcode == OP_HUM)
					n_hum++;
				else
					n_temp++;
			end
			if (start && busy) begin
				nx_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (steps.size() == 0) begin
				feed_done <= 1'b1;
			end else begin
				case (steps[0].kind)
					STEP_SAMPLE: begin
						cur_step = steps.pop_front();
						nx_start = 1'b1;
						cmd <= cur_step.cmd;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 40);
							case ($urandom_range(0, 9))
								0, 1, 2, 3: gap_left = 0;
								4, 5, 6, 7: gap_left = $urandom_range(1, 4);
								8: gap_left = $urandom_range(5, 20);
								default: gap_left = $urandom_range(30, 60);
							endcase
						end
					end
					STEP_WRITE: begin
						cur_step = steps.pop_front();
						nx_we = 1'b1;
						cfg_idx <= cur_step.idx;
						cfg_wdata <= cur_step.data;
						case (cur_step.idx)
							REG_TEMP_P0, REG_TEMP_P1:
								cal_regs[cur_step.idx] = {6'd0, cur_step.data[9:0]};
							REG_HUM_P0, REG_HUM_P1:
								cal_regs[cur_step.idx] = {8'd0, cur_step.data[7:0]};
							default:
								cal_regs[cur_step.idx] = cur_step.data;
						endcase
						n_writes++;
					end
					default: begin
						if (expected_q.size() == 0) begin
							settle_cnt++;
							if (settle_cnt >= DRAIN_SETTLE) begin
								cur_step = steps.pop_front();
								settle_cnt = 0;
							end
						end else begin
							settle_cnt = 0;
						end
					end
				endcase
			end
			start <= nx_start;
			cfg_we <= nx_we;
		end
	end

	// monitor: every done strobe is one result transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected",
					result.calibrated_value));
			end else begin
				want = expected_q.pop_front();
				n_results++;
				if (want.zero_divide)
					n_zdiv++;
				if (result.calibrated_value !== want.calibrated_value)
					report_mismatch($sformatf("calibrated_value %0d, expected %0d",
						result.calibrated_value, want.calibrated_value));
				if (result.zero_divide !== want.zero_divide)
					report_mismatch($sformatf("zero_divide %b, expected %b",
						result.zero_divide, want.zero_divide));
				if (result.saturated !== want.saturated)
					report_mismatch($sformatf("saturated %b, expected %b",
						result.saturated, want.saturated));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", stall_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		// registers at reset: both channels divide by zero
		add_sample(OP_TEMP, 16'h0000);
		add_sample(OP_HUM, 16'h8000);

		// typical calibration
		plan_regs[REG_TEMP_P0] = 16'd200;
		plan_regs[REG_TEMP_P1] = 16'd480;
		plan_regs[REG_TEMP_R0] = -16'sd1200;
		plan_regs[REG_TEMP_R1] = 16'sd5000;
		plan_regs[REG_HUM_P0]  = 16'd60;
		plan_regs[REG_HUM_P1]  = 16'd160;
		plan_regs[REG_HUM_R0]  = -16'sd3000;
		plan_regs[REG_HUM_R1]  = 16'sd12000;
		load_plan();
		add_sample(OP_TEMP, 16'h0000);
		add_sample(OP_TEMP, 16'h7FFF);
		add_sample(OP_TEMP, 16'h8000);
		add_sample(OP_TEMP, -16'sd1200);
		add_sample(OP_TEMP, 16'sd5000);
		add_sample(OP_HUM, 16'h0000);
		add_sample(OP_HUM, 16'h7FFF);
		add_sample(OP_HUM, 16'h8000);
		add_sample(OP_HUM, 16'sd12000);
		add_sample(OP_HUM, -16'sd3000);

		// extreme points; humidity gets the steepest slope
		plan_regs[REG_TEMP_P0] = 16'd1023;
		plan_regs[REG_TEMP_P1] = 16'd0;
		plan_regs[REG_TEMP_R0] = 16'h7FFF;
		plan_regs[REG_TEMP_R1] = 16'h8000;
		plan_regs[REG_HUM_P0]  = 16'd0;
		plan_regs[REG_HUM_P1]  = 16'd255;
		plan_regs[REG_HUM_R0]  = 16'h8000;
		plan_regs[REG_HUM_R1]  = 16'h8001;
		load_plan();
		add_sample(OP_TEMP, 16'h7FFF);
		add_sample(OP_TEMP, 16'h8000);
		add_sample(OP_TEMP, 16'h0000);
		add_sample(OP_HUM, 16'h7FFF);
		add_sample(OP_HUM, 16'h8000);
		add_sample(OP_HUM, 16'h0001);

		// equal raw points with P0 at its top value and P1 at zero, upper data bits set
		plan_regs[REG_TEMP_P0] = 16'hFFFF;
		plan_regs[REG_TEMP_P1] = 16'hFC00;
		plan_regs[REG_TEMP_R0] = -16'sd5;
		plan_regs[REG_TEMP_R1] = -16'sd5;
		plan_regs[REG_HUM_P0]  = 16'hABFF;
		plan_regs[REG_HUM_P1]  = 16'h5400;
		plan_regs[REG_HUM_R0]  = 16'h7FFF;
		plan_regs[REG_HUM_R1]  = 16'h7FFF;
		load_plan();
		add_sample(OP_TEMP, -16'sd5);
		add_sample(OP_TEMP, 16'sd100);
		add_sample(OP_HUM, 16'h7FFF);
		add_sample(OP_HUM, 16'h8000);

		for (int set = 0; set < RANDOM_SETS; set++) begin
			for (int k = 0; k < 8; k++)
				plan_regs[k] = 16'($urandom);
			for (int ch = 0; ch < 2; ch++) begin
				int r0i;
				r0i = (ch == 0) ? int'(REG_TEMP_R0) : int'(REG_HUM_R0);
				case ($urandom_range(0, 6))
					0: plan_regs[r0i + 1] = plan_regs[r0i];
					1: plan_regs[r0i + 1] = plan_regs[r0i] + 16'($urandom_range(1, 8));
					2: plan_regs[r0i + 1] = plan_regs[r0i] - 16'($urandom_range(1, 8));
					default: ;
				endcase
			end
			load_plan();
			for (int i = 0; i < SET_SAMPLES; i++) begin
				add_random_sample();
				if ($urandom_range(0, 59) == 0)
					add_drain();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (feed_done);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		$display("Covered %0d transfers (%0d temperature, %0d humidity), %0d results checked.",
			n_temp + n_hum, n_temp, n_hum, n_results);
		$display("Calibration sets: %0d via %0d register writes; zero-divide results: %0d.",
			n_sets, n_writes, n_zdiv);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
